// ----- hdl/itaf_pkg.sv -----
// Shared constants, codes and the digit character function for the integer formatter.
package itaf_pkg;

  localparam logic [2:0] MODE_SDEC32 = 3'd0;
  localparam logic [2:0] MODE_UDEC32 = 3'd1;
  localparam logic [2:0] MODE_HEXL64 = 3'd2;
  localparam logic [2:0] MODE_HEXL32 = 3'd3;
  localparam logic [2:0] MODE_HEXU32 = 3'd4;

  localparam logic [7:0] CHAR_MINUS = 8'h2D;

  // Reciprocal of ten scaled by 2^35; exact for every 32-bit dividend.
  localparam logic [31:0] RECIP_TEN = 32'hCCCC_CCCD;
  localparam int unsigned RECIP_SHIFT = 35;

  function automatic logic [7:0] digit_char(input logic [3:0] digit, input logic upper);
    logic [7:0] code;
    if (digit < 4'd10) begin
      code = 8'h30 + {4'd0, digit};
    end else if (upper) begin
      code = 8'h37 + {4'd0, digit};
    end else begin
      code = 8'h57 + {4'd0, digit};
    end
    return code;
  endfunction

endpackage

// ----- hdl/itaf_div10.sv -----
// Divide-by-ten unit: registered reciprocal multiply, then quotient and remainder.
module itaf_div10 (
  input  logic        clk_i,
  input  logic [31:0] x_i,
  output logic [31:0] quot_o,
  output logic [3:0]  rem_o
);

  logic [63:0] prod_q;
  logic [31:0] times_ten;
  logic [31:0] diff;

  always_ff @(posedge clk_i) begin
    prod_q <= 64'(x_i) * 64'(itaf_pkg::RECIP_TEN);
  end

  assign quot_o    = 32'(prod_q >> itaf_pkg::RECIP_SHIFT);
  assign times_ten = (quot_o << 3) + (quot_o << 1);
  assign diff      = x_i - times_ten;
  assign rem_o     = diff[3:0];

endmodule

// ----- hdl/integer_to_ascii_formatter_top.sv -----
// Top level of the integer to ASCII formatter: sequencer, digit buffer and output register.
//
//   Channel | Direction | Payload                          | Handshake
//   in      | sink      | mode_i, value_i                  | in_valid_i / in_ready_o
//   out     | source    | char_code_o, char_number_o, last_o | out_valid_o / out_ready_i
//
// A decimal digit goes through the divide-by-ten multiplier (MUL, then DIG), a hex digit
// through DIG alone; then one character leaves per cycle unless stalled, up to sixteen.
// The input is ready only while the sequencer is idle; a stalled output holds the sequencer.
// Reset clears the sequencer and the output valid flag; unused modes yield no characters.
module integer_to_ascii_formatter_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  mode_i,
  input  logic [63:0] value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  char_code_o,
  output logic [4:0]  char_number_o,
  output logic        last_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_DIG  = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]  state_q, state_d;
  logic [63:0] mag_q, mag_d;
  logic        dec_q, dec_d;
  logic        upper_q, upper_d;
  logic        sign_q, sign_d;
  logic [3:0]  wr_q, wr_d;
  logic [3:0]  rd_q, rd_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [3:0]  digits_q [16];

  logic        out_valid_q, out_valid_d;
  logic [7:0]  char_q, char_d;
  logic [4:0]  num_q, num_d;
  logic        last_q, last_d;

  logic [31:0] quot;
  logic [3:0]  rem;
  logic [3:0]  digit;
  logic [63:0] mag_next;
  logic        buf_we;
  logic        out_free;
  logic        accept;
  logic [31:0] low32;

  itaf_div10 u_div10 (
    .clk_i  (clk_i),
    .x_i    (mag_q[31:0]),
    .quot_o (quot),
    .rem_o  (rem)
  );

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign low32      = value_i[31:0];
  assign digit      = dec_q ? rem : mag_q[3:0];
  assign mag_next   = dec_q ? {32'd0, quot} : (mag_q >> 4);
  assign buf_we     = (state_q == ST_DIG);

  always_comb begin
    state_d     = state_q;
    mag_d       = mag_q;
    dec_d       = dec_q;
    upper_d     = upper_q;
    sign_d      = sign_q;
    wr_d        = wr_q;
    rd_d        = rd_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    char_d      = char_q;
    num_d       = num_q;
    last_d      = last_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          wr_d    = 4'd0;
          cnt_d   = 5'd0;
          upper_d = (mode_i == itaf_pkg::MODE_HEXU32);
          dec_d   = (mode_i == itaf_pkg::MODE_SDEC32) || (mode_i == itaf_pkg::MODE_UDEC32);
          sign_d  = (mode_i == itaf_pkg::MODE_SDEC32) && low32[31];
          if (mode_i == itaf_pkg::MODE_HEXL64) begin
            mag_d = value_i;
          end else if ((mode_i == itaf_pkg::MODE_SDEC32) && low32[31]) begin
            mag_d = {32'd0, 32'd0 - low32};
          end else begin
            mag_d = {32'd0, low32};
          end
          if ((mode_i == itaf_pkg::MODE_SDEC32) || (mode_i == itaf_pkg::MODE_UDEC32)) begin
            state_d = ST_MUL;
          end else if ((mode_i == itaf_pkg::MODE_HEXL64) || (mode_i == itaf_pkg::MODE_HEXL32) ||
                       (mode_i == itaf_pkg::MODE_HEXU32)) begin
            state_d = ST_DIG;
          end
        end
      end
      ST_MUL: begin
        state_d = ST_DIG;
      end
      ST_DIG: begin
        mag_d = mag_next;
        if (mag_next == 64'd0) begin
          rd_d    = wr_q;
          state_d = ST_EMIT;
        end else begin
          wr_d    = wr_q + 4'd1;
          state_d = dec_q ? ST_MUL : ST_DIG;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          num_d       = cnt_q + 5'd1;
          cnt_d       = cnt_q + 5'd1;
          if (sign_q) begin
            char_d = itaf_pkg::CHAR_MINUS;
            last_d = 1'b0;
            sign_d = 1'b0;
          end else begin
            char_d = itaf_pkg::digit_char(digits_q[rd_q], upper_q);
            last_d = (rd_q == 4'd0);
            rd_d   = rd_q - 4'd1;
            if (rd_q == 4'd0) begin
              state_d = ST_IDLE;
            end
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q   <= mag_d;
    dec_q   <= dec_d;
    upper_q <= upper_d;
    sign_q  <= sign_d;
    wr_q    <= wr_d;
    rd_q    <= rd_d;
    cnt_q   <= cnt_d;
    char_q  <= char_d;
    num_q   <= num_d;
    last_q  <= last_d;
    if (buf_we) begin
      digits_q[wr_q] <= digit;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign char_code_o   = char_q;
  assign char_number_o = num_q;
  assign last_o        = last_q;

endmodule

// ----- tb/integer_to_ascii_formatter_top_test.sv -----
// Self-checking testbench that predicts each character stream and compares it to the formatter.
module integer_to_ascii_formatter_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] MODE_RSVD5 = 3'd5;
  localparam logic [2:0] MODE_RSVD6 = 3'd6;
  localparam logic [2:0] MODE_RSVD7 = 3'd7;

  localparam logic [7:0] ASCII_ZERO = 8'h30;
  localparam logic [7:0] ASCII_LOWER_A = 8'h61;
  localparam logic [7:0] ASCII_UPPER_A = 8'h41;
  localparam int MAX_CHARS = 16;
  localparam int RANDOM_ITEMS = 280;
  localparam int DRAIN_CYCLES = 60;
  localparam int LIMIT_CYCLES = 400000;

  typedef struct packed {
    logic [7:0] code;
    logic [4:0] number;
    logic       last;
  } glyph_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [2:0]  mode_i = itaf_pkg::MODE_SDEC32;
  logic [63:0] value_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [7:0]  char_code_o;
  logic [4:0]  char_number_o;
  logic        last_o;

  glyph_t pending_glyphs[$];
  int     error_count = 0;
  int     cycle_count = 0;
  int     burst_left = 0;
  int     stall_style = 0;
  int     stall_hold = 0;
  int     stall_phase = 0;

  integer_to_ascii_formatter_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .mode_i        (mode_i),
    .value_i       (value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .char_code_o   (char_code_o),
    .char_number_o (char_number_o),
    .last_o        (last_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [7:0] digit_glyph(input logic [3:0] digit, input logic upper);
    if (digit < 4'd10) begin
      return ASCII_ZERO + 8'(digit);
    end
    return (upper ? ASCII_UPPER_A : ASCII_LOWER_A) + 8'(digit) - 8'd10;
  endfunction

  function automatic void predict_text(input logic [2:0] mode, input logic [63:0] value);
    logic [63:0] mag;
    logic [63:0] radix;
    logic [31:0] low_mag;
    logic        upper;
    logic [7:0]  rev_digits[MAX_CHARS];
    logic [7:0]  text[MAX_CHARS];
    int          n_digits;
    int          n_text;
    glyph_t      g;
    n_digits = 0;
    n_text = 0;
    upper = 1'b0;
    radix = 64'd16;
    case (mode)
      itaf_pkg::MODE_SDEC32: begin
        low_mag = value[31] ? (~value[31:0] + 32'd1) : value[31:0];
        mag = {32'd0, low_mag};
        radix = 64'd10;
        if (value[31]) begin
          text[n_text] = itaf_pkg::CHAR_MINUS;
          n_text++;
        end
      end
      itaf_pkg::MODE_UDEC32: begin
        mag = {32'd0, value[31:0]};
        radix = 64'd10;
      end
      itaf_pkg::MODE_HEXL64: mag = value;
      itaf_pkg::MODE_HEXL32: mag = {32'd0, value[31:0]};
      itaf_pkg::MODE_HEXU32: begin
        mag = {32'd0, value[31:0]};
        upper = 1'b1;
      end
      default: return;
    endcase
    do begin
      rev_digits[n_digits] = digit_glyph(4'(mag % radix), upper);
      n_digits++;
      mag = mag / radix;
    end while (mag != 0 && n_digits < MAX_CHARS);
    for (int i = n_digits - 1; i >= 0 && n_text < MAX_CHARS; i--) begin
      text[n_text] = rev_digits[i];
      n_text++;
    end
    for (int i = 0; i < n_text; i++) begin
      g.code = text[i];
      g.number = 5'(i + 1);
      g.last = (i == n_text - 1);
      pending_glyphs.push_back(g);
    end
  endfunction

  task automatic send_item(input logic [2:0] mode, input logic [63:0] value);
    int gap;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    mode_i <= mode;
    value_i <= value;
    do @(posedge clk_i); while (!in_ready_o);
    predict_text(mode, value);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 6);
      gap = $urandom_range(0, 12);
      if (gap > 0) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        mode_i <= 3'($urandom);
        value_i <= {$urandom, $urandom};
        repeat (gap - 1) @(negedge clk_i);
      end
    end
  endtask

  task automatic test_signed_decimal;
    send_item(itaf_pkg::MODE_SDEC32, 64'd0);
    send_item(itaf_pkg::MODE_SDEC32, 64'd1);
    send_item(itaf_pkg::MODE_SDEC32, 64'h0000_0000_FFFF_FFFF);
    send_item(itaf_pkg::MODE_SDEC32, 64'h0000_0000_7FFF_FFFF);
    send_item(itaf_pkg::MODE_SDEC32, 64'h0000_0000_8000_0000);
    send_item(itaf_pkg::MODE_SDEC32, 64'hDEAD_BEEF_FFFF_FFF6);
  endtask

  task automatic test_unsigned_decimal;
    send_item(itaf_pkg::MODE_UDEC32, 64'd0);
    send_item(itaf_pkg::MODE_UDEC32, 64'h0000_0000_FFFF_FFFF);
    send_item(itaf_pkg::MODE_UDEC32, 64'd1_000_000_000);
    send_item(itaf_pkg::MODE_UDEC32, 64'hFFFF_FFFF_0000_0009);
  endtask

  task automatic test_hex_wide;
    send_item(itaf_pkg::MODE_HEXL64, 64'd0);
    send_item(itaf_pkg::MODE_HEXL64, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(itaf_pkg::MODE_HEXL64, 64'h8000_0000_0000_0000);
    send_item(itaf_pkg::MODE_HEXL64, 64'h0123_4567_89AB_CDEF);
  endtask

  task automatic test_hex_narrow;
    send_item(itaf_pkg::MODE_HEXL32, 64'd0);
    send_item(itaf_pkg::MODE_HEXL32, 64'h1234_5678_FFFF_FFFF);
    send_item(itaf_pkg::MODE_HEXL32, 64'h0000_0000_ABCD_EF01);
    send_item(itaf_pkg::MODE_HEXU32, 64'd0);
    send_item(itaf_pkg::MODE_HEXU32, 64'hFFFF_FFFF_ABCD_EF01);
    send_item(itaf_pkg::MODE_HEXU32, 64'h0000_0000_0000_000F);
  endtask

  task automatic test_unused_modes;
    send_item(MODE_RSVD5, 64'h0123_4567_89AB_CDEF);
    send_item(MODE_RSVD6, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(MODE_RSVD7, 64'd0);
  endtask

  task automatic test_random_items;
    logic [2:0]  mode;
    logic [63:0] value;
    repeat (RANDOM_ITEMS) begin
      if ($urandom_range(0, 99) < 8) begin
        case ($urandom_range(0, 2))
          0: mode = MODE_RSVD5;
          1: mode = MODE_RSVD6;
          default: mode = MODE_RSVD7;
        endcase
      end else begin
        case ($urandom_range(0, 4))
          0: mode = itaf_pkg::MODE_SDEC32;
          1: mode = itaf_pkg::MODE_UDEC32;
          2: mode = itaf_pkg::MODE_HEXL64;
          3: mode = itaf_pkg::MODE_HEXL32;
          default: mode = itaf_pkg::MODE_HEXU32;
        endcase
      end
      case ($urandom_range(0, 3))
        0: value = {$urandom, $urandom};
        1: value = {$urandom, $urandom} >> $urandom_range(0, 63);
        2: value = {$urandom, 32'($urandom_range(0, 20))};
        default: value = {$urandom, 32'h8000_0000 ^ 32'($urandom_range(0, 3))}
                         ^ {32'd0, {32{$urandom_range(0, 1) == 1}}};
      endcase
      send_item(mode, value);
    end
  endtask

  always @(negedge clk_i) begin
    if (stall_hold == 0) begin
      stall_style <= $urandom_range(0, 3);
      stall_hold <= $urandom_range(30, 200);
    end else begin
      stall_hold <= stall_hold - 1;
    end
    stall_phase <= stall_phase + 1;
    case (stall_style)
      0: out_ready_i <= 1'b1;
      1: out_ready_i <= ($urandom_range(0, 1) == 1);
      2: out_ready_i <= (stall_phase % 4 == 0);
      default: out_ready_i <= ($urandom_range(0, 5) == 0);
    endcase
  end

  always @(posedge clk_i) begin
    glyph_t seen;
    glyph_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      seen = '{code: char_code_o, number: char_number_o, last: last_o};
      if (pending_glyphs.size() == 0) begin
        $display("%0t: unexpected character code=%h number=%0d last=%b",
                 $time, seen.code, seen.number, seen.last);
        error_count++;
      end else begin
        want = pending_glyphs.pop_front();
        if (seen !== want) begin
          $display({"%0t: mismatch expected code=%h number=%0d last=%b,",
                    " actual code=%h number=%0d last=%b"},
                   $time, want.code, want.number, want.last,
                   seen.code, seen.number, seen.last);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("** integer_to_ascii_formatter_top: FAILED **");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_signed_decimal();
    test_unsigned_decimal();
    test_hex_wide();
    test_hex_narrow();
    test_unused_modes();
    test_random_items();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_glyphs.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0 && pending_glyphs.size() == 0) begin
      $display("** integer_to_ascii_formatter_top: PASSED **");
    end else begin
      $display("** integer_to_ascii_formatter_top: FAILED **");
    end
    $finish;
  end

endmodule

// ----- integer_to_ascii_formatter_top.f -----
hdl/itaf_pkg.sv
hdl/itaf_div10.sv
hdl/integer_to_ascii_formatter_top.sv
tb/integer_to_ascii_formatter_top_test.sv
